[rtl/radix_converter_macros.svh]
// Assertion macros for the radix converter.
`ifndef RADIX_CONVERTER_MACROS_SVH
`define RADIX_CONVERTER_MACROS_SVH

// expression holds at every rising clock edge out of reset
`define RC_ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/rc_pkg.sv]
// Shared types, constants and alphabet functions of the radix converter.
package rc_pkg;

    localparam int unsigned BASE_W      = 6;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [BASE_W-1:0] ALPHA_LEN  = 6'd62;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_RD,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [BASE_W-1:0] idx;
        logic              last;
    } t_entry;

    typedef struct packed {
        t_state state;
    } t_back_status;

    function automatic logic [BASE_W-1:0] char_to_index(input logic [CHAR_W-1:0] c);
        logic [BASE_W-1:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = BASE_W'(c - 8'h30);
        end else if (c inside {[8'h41:8'h5A]}) begin
            r = BASE_W'(c - 8'h37);
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = BASE_W'(c - 8'h3D);
        end else begin
            r = ALPHA_LEN;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] index_to_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 6'd10) begin
            r = CHAR_W'(d) + 8'h30;
        end else if (d < 6'd36) begin
            r = CHAR_W'(d) + 8'h37;
        end else if (d < ALPHA_LEN) begin
            r = CHAR_W'(d) + 8'h3D;
        end else begin
            r = 8'h30;
        end
        return r;
    endfunction

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN) begin
            r = BASE_MIN;
        end else if (b > ALPHA_LEN) begin
            r = ALPHA_LEN;
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

[rtl/rc_front.sv]
// Input side: takes characters and maps them to alphabet indices for the queue.
module rc_front (
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] char_code
    input  logic             i_s_tlast,   // last_char
    input  logic             i_q_full,
    output logic             o_push,
    output rc_pkg::t_entry   o_entry
);
    import rc_pkg::*;

    assign o_s_tready    = i_rst_n && !i_q_full;
    assign o_push        = i_s_tvalid && o_s_tready;
    assign o_entry.idx   = char_to_index(i_s_tdata);
    assign o_entry.last  = i_s_tlast;

endmodule

[rtl/rc_queue.sv]
// Short queue of classified characters between the front and the back.
module rc_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  rc_pkg::t_entry             i_entry,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic                       o_valid,
    output rc_pkg::t_entry             o_entry,
    output logic [rc_pkg::QCNT_W-1:0]  o_count
);
    import rc_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wptr;
    logic [QPTR_W-1:0]   r_rptr;
    logic [QCNT_W-1:0]   r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign o_count = r_count;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[rtl/rc_back.sv]
// Back end: accumulates digits, converts by bit-serial division, emits digits.
module rc_back #(
    parameter int unsigned NUM_WIDTH  = 32,
    parameter int unsigned MAX_DIGITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rc_pkg::BASE_W-1:0]  i_in_base,
    input  logic [rc_pkg::BASE_W-1:0]  i_out_base,
    input  logic                       i_q_valid,
    input  rc_pkg::t_entry             i_q_entry,
    output logic                       o_pop,
    output logic                       o_m_valid,
    input  logic                       i_m_ready,
    output logic [rc_pkg::CHAR_W-1:0]  o_m_char,
    output logic                       o_m_last,
    output rc_pkg::t_back_status       o_status
);
    import rc_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int unsigned ADDR_W = $clog2(MAX_DIGITS);
    localparam int unsigned BIT_W  = $clog2(NUM_WIDTH);

    t_state               r_state, n_state;
    logic [NUM_WIDTH-1:0] r_acc, n_acc;
    logic [NUM_WIDTH-1:0] r_val, n_val;
    logic [BASE_W-1:0]    r_rem, n_rem;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [ADDR_W-1:0]    r_ptr, n_ptr;
    logic [BASE_W-1:0]    r_rd_data;
    logic [BASE_W-1:0]    r_store [MAX_DIGITS];
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;

    logic [BASE_W-1:0]    w_ib;
    logic [BASE_W-1:0]    w_ob;
    logic [NUM_WIDTH-1:0] w_acc_sum;
    logic [BASE_W:0]      w_trial;
    logic                 w_ge;
    logic [BASE_W-1:0]    w_rem_step;
    logic [NUM_WIDTH-1:0] w_quo_step;
    logic                 w_last_bit;
    logic                 w_room;
    logic [CNT_W-1:0]     w_n_inc;
    logic                 w_out_free;
    logic                 w_load;

    assign w_ib      = clamp_base(i_in_base);
    assign w_ob      = clamp_base(i_out_base);
    assign w_acc_sum = r_acc * NUM_WIDTH'(w_ib) + NUM_WIDTH'(i_q_entry.idx);

    // one restoring division step per cycle
    assign w_trial    = {r_rem, r_val[NUM_WIDTH-1]};
    assign w_ge       = (w_trial >= {1'b0, w_ob});
    assign w_rem_step = w_ge ? BASE_W'(w_trial - {1'b0, w_ob}) : w_trial[BASE_W-1:0];
    assign w_quo_step = {r_val[NUM_WIDTH-2:0], w_ge};
    assign w_last_bit = (r_bit == BIT_W'(NUM_WIDTH - 1));
    assign w_room     = (r_n < CNT_W'(MAX_DIGITS));
    assign w_n_inc    = w_room ? r_n + 1'b1 : r_n;

    assign w_out_free = !r_out_valid || i_m_ready;
    assign o_pop      = (r_state == ST_ACC) && i_q_valid;
    assign w_load     = (r_state == ST_LOAD) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACC: begin
                if (i_q_valid && i_q_entry.last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_last_bit && (w_quo_step == '0)) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (w_out_free) begin
                    n_state = (r_ptr == '0) ? ST_ACC : ST_RD;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    always_comb begin
        n_acc = r_acc;
        n_val = r_val;
        n_rem = r_rem;
        n_bit = r_bit;
        n_n   = r_n;
        n_ptr = r_ptr;
        case (r_state)
            ST_ACC: begin
                if (i_q_valid) begin
                    if (i_q_entry.last) begin
                        n_acc = '0;
                        n_val = w_acc_sum;
                        n_rem = '0;
                        n_bit = '0;
                        n_n   = '0;
                    end else begin
                        n_acc = w_acc_sum;
                    end
                end
            end
            ST_DIV: begin
                n_val = w_quo_step;
                if (w_last_bit) begin
                    n_rem = '0;
                    n_bit = '0;
                    n_n   = w_n_inc;
                    n_ptr = ADDR_W'(w_n_inc - 1'b1);
                end else begin
                    n_rem = w_rem_step;
                    n_bit = r_bit + 1'b1;
                end
            end
            ST_LOAD: begin
                if (w_out_free && (r_ptr != '0)) begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DIV) && w_last_bit && w_room) begin
            r_store[r_n[ADDR_W-1:0]] <= w_rem_step;
        end
        if (r_state == ST_RD) begin
            r_rd_data <= r_store[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_acc       <= '0;
            r_n         <= '0;
            r_ptr       <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_n     <= n_n;
            r_ptr   <= n_ptr;
            r_bit   <= n_bit;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_rem <= n_rem;
        if (w_load) begin
            r_out_char <= index_to_char(r_rd_data);
            r_out_last <= (r_ptr == '0);
        end
    end

    assign o_m_valid      = r_out_valid;
    assign o_m_char       = r_out_char;
    assign o_m_last       = r_out_last;
    assign o_status.state = r_state;

endmodule

[rtl/radix_converter.sv]
// Radix converter top level: base-62 alphabet digits in, digits in another radix out.
//
// Input stream (s_axis): one ASCII character per transfer, tlast on the final
// character of a number. Characters map to 0-9A-Za-z indices, others to 62.
// Output stream (m_axis): the value's digits in the output radix, most
// significant first, tlast on the final digit. Zero gives the single digit '0'.
// Config channel: index 0 writes in_base, index 1 writes out_base (6 bits,
// used clamped to 2..62); other indices are ignored. Write only when idle.
// An ordinary character passes through the back end's multiply-add, and up
// to four wait in the input queue. The final character goes through the
// bit-serial divider once per output digit; each digit is then read from
// the digit memory and loaded into the output register.
// Reset (synchronous, active low) clears the value, queue and output; both
// radices return to 10. A stalled receiver holds the output register and
// stops the back end in its load state; the queue still takes characters until full.
module radix_converter #(
    parameter int unsigned NUM_WIDTH  = 32,
    parameter int unsigned MAX_DIGITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] char_code
    input  logic                          s_axis_tlast,   // last_char
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,   // [7:0] digit_char
    output logic                          m_axis_tlast,   // last_digit
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rc_pkg::BASE_W-1:0]     i_cfg_data
);
    import rc_pkg::*;

    `include "radix_converter_macros.svh"

    logic [BASE_W-1:0]  r_in_base;
    logic [BASE_W-1:0]  r_out_base;
    logic               w_push;
    t_entry             w_push_entry;
    logic               w_q_full;
    logic               w_pop;
    logic               w_q_valid;
    t_entry             w_q_entry;
    logic [QCNT_W-1:0]  w_q_count;
    t_back_status       w_back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_base  <= BASE_RESET;
            r_out_base <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IN_BASE:  r_in_base  <= i_cfg_data;
                REG_OUT_BASE: r_out_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rc_front u_front (
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    rc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry),
        .o_count (w_q_count)
    );

    rc_back #(
        .NUM_WIDTH  (NUM_WIDTH),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_base  (r_in_base),
        .i_out_base (r_out_base),
        .i_q_valid  (w_q_valid),
        .i_q_entry  (w_q_entry),
        .o_pop      (w_pop),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_char   (m_axis_tdata),
        .o_m_last   (m_axis_tlast),
        .o_status   (w_back_status)
    );

    `RC_ASSERT_HOLDS(a_queue_bound, i_clk, i_rst_n,
        w_q_count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `RC_ASSERT_IMPLIES(a_accept_room, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        w_q_count < QCNT_W'(QUEUE_DEPTH), "transfer taken into full queue")
    `RC_ASSERT_IMPLIES(a_out_from_load, i_clk, i_rst_n, $rose(m_axis_tvalid),
        $past(w_back_status.state) == ST_LOAD, "digit shown outside load state")

endmodule
